// ===== src/bsa_pkg.sv =====
`default_nettype none

package bsa_pkg;

  // Request codes carried on in_tuser.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_BASE = 8'd0;
  localparam logic [7:0] CFG_SLOT = 8'd1;

  // Field widths.
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 33;
  localparam int unsigned PROD_W = IDX_W + SIZE_W;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned IN_W   = 8;
  localparam int unsigned OUT_W  = 64;

  // Register reset values.
  localparam logic [ADDR_W-1:0] BASE_RESET = '0;
  localparam logic [SIZE_W-1:0] SLOT_RESET = SIZE_W'(64);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // latch a request and update the bitmap
    logic load_out;  // finish the address and load the output register
  } bsa_cmd_t;

endpackage

`default_nettype wire

// ===== src/bsa_ctrl.sv =====
`default_nettype none

module bsa_ctrl
  import bsa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  wire logic out_tready,
  output bsa_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_ADDR = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // A request is taken only when no earlier one is still in the address step.
  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign cmd.take     = in_tvalid && in_tready;
  assign cmd.load_out = (state_r == S_ADDR) && (!out_valid_r || out_tready);

  // Next state and output valid.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.take) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (cmd.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/bsa_datapath.sv =====
`default_nettype none

module bsa_datapath
  import bsa_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bsa_cmd_t          cmd,
  input  wire logic              req_opcode,
  input  wire logic [IDX_W-1:0]  req_slot,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output logic [1:0]             res_status,
  output logic [IDX_W-1:0]       res_index,
  output logic [ADDR_W-1:0]      res_address,
  output logic                   res_full,
  output logic                   res_avail
);

  localparam int unsigned MAP_IDX_W = $clog2(SLOT_COUNT);

  logic [ADDR_W-1:0]     base_r;
  logic [SIZE_W-1:0]     slot_bytes_r;
  logic [SLOT_COUNT-1:0] free_map_r, free_map_nxt;

  // Request stage registers.
  logic [1:0]        status_r, status_nxt;
  logic [IDX_W-1:0]  gidx_r, gidx_nxt;
  logic              grant_r, grant_nxt;
  logic              full_r, full_nxt;
  logic              avail_r, avail_nxt;
  logic [PROD_W-1:0] prod_r;

  // Output register.
  logic [1:0]        out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_full_r;
  logic              out_avail_r;

  logic [MAP_IDX_W-1:0]  enc_pos;
  logic                  any_free;
  logic                  in_range;
  logic [MAP_IDX_W-1:0]  free_sel;
  logic [SLOT_COUNT-1:0] alloc_map;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= BASE_RESET;
      slot_bytes_r <= SLOT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE) begin
        base_r <= cfg_data[ADDR_W-1:0];
      end else if (cfg_index == CFG_SLOT) begin
        slot_bytes_r <= cfg_data[SIZE_W-1:0];
      end
    end
  end

  // Priority encoder: highest-numbered free slot.
  always_comb begin
    enc_pos = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (free_map_r[i]) begin
        enc_pos = MAP_IDX_W'(i);
      end
    end
  end

  assign any_free  = |free_map_r;
  assign in_range  = {1'b0, req_slot} < (IDX_W + 1)'(SLOT_COUNT);
  assign free_sel  = req_slot[MAP_IDX_W-1:0];
  assign alloc_map = free_map_r & ~(SLOT_COUNT'(1) << enc_pos);

  // Request decode and bitmap update.
  always_comb begin
    free_map_nxt = free_map_r;
    status_nxt   = ST_OK;
    gidx_nxt     = '0;
    grant_nxt    = 1'b0;
    full_nxt     = 1'b0;
    avail_nxt    = 1'b0;
    if (req_opcode == OP_ALLOC) begin
      if (!any_free) begin
        status_nxt = ST_NO_SLOT;
      end else begin
        free_map_nxt = alloc_map;
        gidx_nxt     = IDX_W'(enc_pos);
        grant_nxt    = 1'b1;
        full_nxt     = (alloc_map == '0);
      end
    end else begin
      if (!in_range || free_map_r[free_sel]) begin
        status_nxt = ST_REJECT;
      end else begin
        avail_nxt              = (free_map_r == '0);
        free_map_nxt[free_sel] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r <= '1;
    end else if (cmd.take) begin
      free_map_r <= free_map_nxt;
    end
  end

  // First step: latch the decoded request and form the slot offset.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      status_r <= status_nxt;
      gidx_r   <= gidx_nxt;
      grant_r  <= grant_nxt;
      full_r   <= full_nxt;
      avail_r  <= avail_nxt;
      prod_r   <= PROD_W'(gidx_nxt) * PROD_W'(slot_bytes_r);
    end
  end

  // Second step: add the base and load the output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_index_r  <= gidx_r;
      out_full_r   <= full_r;
      out_avail_r  <= avail_r;
      out_addr_r   <= grant_r ? (base_r + ADDR_W'(prod_r)) : '0;
    end
  end

  assign res_status  = out_status_r;
  assign res_index   = out_index_r;
  assign res_address = out_addr_r;
  assign res_full    = out_full_r;
  assign res_avail   = out_avail_r;

endmodule

`default_nettype wire

// ===== src/bitmap_slot_allocator.sv =====
// out_tvalid rises once the address step has loaded the output register, which waits
// while an earlier result is still held there and out_tready is low.
// Requests are not overlapped: the two-step sequence of bitmap update with slot-offset
// multiply, then the base-address add, must finish before a new request is taken.
// The output register lets a new request enter while a result waits.
// Reset (synchronous, rst_n low): every slot free, base address 0, slot size 64,
// no result pending.
`default_nettype none

module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Request channel.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,   // [5:0] slot_index, [7:6] zero
  input  wire logic              in_tuser,   // opcode
  // Result channel.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata,  // [1:0] status, [7:2] granted_index,
                                             // [55:8] granted_address,
                                             // [56] became_full,
                                             // [57] became_available, [63:58] zero
  // Configuration write channel.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  bsa_cmd_t          cmd;
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  res_index;
  logic [ADDR_W-1:0] res_address;
  logic              res_full;
  logic              res_avail;

  assign cfg_ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_opcode  (in_tuser),
    .req_slot    (in_tdata[IDX_W-1:0]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .res_status  (res_status),
    .res_index   (res_index),
    .res_address (res_address),
    .res_full    (res_full),
    .res_avail   (res_avail)
  );

  // Pack the result beat, lowest field first.
  assign out_tdata = {6'b0, res_avail, res_full, res_address, res_index, res_status};

endmodule

`default_nettype wire

// ===== src/bsa_checker.sv =====
`default_nettype none

module bsa_checker
  import bsa_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == ST_OK || out_tdata[1:0] == ST_NO_SLOT ||
                    out_tdata[1:0] == ST_REJECT))
    else $error("undefined status code");

  // A failed request carries no grant and no flags.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[57:2] == '0)
    else $error("failed request carries grant data");

  // One request cannot both fill and reopen the pool.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[56] && out_tdata[57]))
    else $error("became_full and became_available both set");

  // In the cycle after a request beat the block is busy.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in progress");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
